// ===== design/rapq_pkg.sv =====
// Package for the range-add / point-read store.
// Holds the word field widths, operation codes and sequencer state type.
// No dependencies.
`default_nettype none

package rapq_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int LEN_W   = 11;
  localparam int OP_W    = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_QUERY  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== design/rapq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on rapq_pkg for the data width.
`default_nettype none

module rapq_ram
  import rapq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [VALUE_W-1:0]         wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [VALUE_W-1:0]         rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/range_add_point_query_tree.sv =====
// Top level of the range-add / point-read store: sequencer, shared adder, memories.
// Depends on rapq_pkg and rapq_ram.
//
// Usage:
//   Input word: in_operation, in_first_index, in_last_index, in_amount, taken at a
//   rising edge with start high and busy low. Operations: load a base value, add an
//   amount over an inclusive index range, read one element.
//   Result word: out_element_value and out_index_error, shown for one cycle with
//   out_strobe high; only a read produces one. The receiver cannot stall.
//   Configuration: cfg_we with cfg_wdata writes the array length; write only while idle.
//
// Operation:
//   The difference array is kept as a binary indexed tree in one RAM, walked one node
//   per cycle through a single 32-bit adder. A load writes the base value while the
//   sequencer stays idle. A range add makes two upward walks, read and write overlapped.
//   A read walks down the tree and adds the base value; an out-of-range read answers
//   in the next cycle.
// Reset:
//   rst_n low clears the sequencer and sets the length to 1024. After reset a clearing
//   pass writes zero to every tree node, with busy high throughout.
`default_nettype none

module range_add_point_query_tree
  import rapq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [OP_W-1:0]           in_operation,
  input  wire logic [INDEX_W-1:0]        in_first_index,
  input  wire logic [INDEX_W-1:0]        in_last_index,
  input  wire logic signed [VALUE_W-1:0] in_amount,
  output logic                           out_strobe,
  output logic signed [VALUE_W-1:0]      out_element_value,
  output logic                           out_index_error,
  input  wire logic                      cfg_we,
  input  wire logic [LEN_W-1:0]          cfg_wdata
);

  localparam int IW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]   len_r;
  logic [IW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      b_i_r, b_i_nxt;
  logic               b_pend_r, b_pend_nxt;
  logic               pend_r, pend_nxt;
  logic [IW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [VALUE_W-1:0] amt_r, amt_nxt;
  logic [VALUE_W-1:0] sum_r, sum_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_err_r, out_err_nxt;

  logic [CMPW-1:0]    eff_len, first_ext, lastp1_ext, len_ext;
  logic               first_ok, last_ok, accept;
  logic [CW-1:0]      i_first, i_last, lowbit, i_up, i_down;
  logic [CW:0]        up_sum;
  logic [IW-1:0]      rd_addr, base_addr;

  logic               tree_wr_en, tree_rd_en;
  logic [IW-1:0]      tree_wr_addr;
  logic [VALUE_W-1:0] tree_wr_data, tree_rd_data;
  logic               base_wr_en, base_rd_en;
  logic [VALUE_W-1:0] base_rd_data;

  logic [VALUE_W-1:0] add_a, add_b, add_y;

  // effective length and index checks
  assign len_ext    = CMPW'(len_r);
  assign eff_len    = (len_ext > CMPW'(MAX_ELEMENTS)) ? CMPW'(MAX_ELEMENTS) : len_ext;
  assign first_ext  = CMPW'(in_first_index);
  assign lastp1_ext = CMPW'(in_last_index) + CMPW'(1);
  assign first_ok   = first_ext < eff_len;
  assign last_ok    = lastp1_ext < eff_len;
  assign i_first    = CW'(first_ext + CMPW'(1));
  assign i_last     = CW'(lastp1_ext + CMPW'(1));
  assign base_addr  = first_ext[IW-1:0];

  // tree index stepping
  assign lowbit  = i_r & (~i_r + CW'(1));
  assign up_sum  = {1'b0, i_r} + {1'b0, lowbit};
  assign i_up    = (up_sum > (CW+1)'(MAX_ELEMENTS)) ? '0 : up_sum[CW-1:0];
  assign i_down  = i_r & (i_r - CW'(1));
  assign rd_addr = IW'(i_r - CW'(1));

  // shared adder
  assign add_a = (state_r == ST_UPDATE) ? amt_r : sum_r;
  assign add_b = pend_r ? tree_rd_data : base_rd_data;
  assign add_y = add_a + add_b;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign tree_wr_en   = (state_r == ST_CLEAR) || ((state_r == ST_UPDATE) && pend_r);
  assign tree_wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : pend_addr_r;
  assign tree_wr_data = (state_r == ST_CLEAR) ? '0 : add_y;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    i_nxt          = i_r;
    b_i_nxt        = b_i_r;
    b_pend_nxt     = b_pend_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    amt_nxt        = amt_r;
    sum_nxt        = sum_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    out_err_nxt    = out_err_r;
    tree_rd_en     = 1'b0;
    base_wr_en     = 1'b0;
    base_rd_en     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + IW'(1);
        if (clr_addr_r == IW'(MAX_ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_LOAD: begin
              base_wr_en = first_ok;
            end
            OP_ADD: begin
              state_nxt  = ST_UPDATE;
              i_nxt      = first_ok ? i_first : '0;
              amt_nxt    = in_amount;
              b_pend_nxt = last_ok;
              b_i_nxt    = i_last;
            end
            OP_READ: begin
              if (first_ok) begin
                base_rd_en = 1'b1;
                i_nxt      = i_first;
                sum_nxt    = '0;
                state_nxt  = ST_QUERY;
              end else begin
                out_strobe_nxt = 1'b1;
                out_value_nxt  = '0;
                out_err_nxt    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_UPDATE: begin
        if (i_r != '0) begin
          tree_rd_en    = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr;
          i_nxt         = i_up;
        end else if (b_pend_r) begin
          i_nxt      = b_i_r;
          amt_nxt    = '0 - amt_r;
          b_pend_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (pend_r) begin
          sum_nxt = add_y;
        end
        if (i_r != '0) begin
          tree_rd_en = 1'b1;
          pend_nxt   = 1'b1;
          i_nxt      = i_down;
        end else if (!pend_r) begin
          out_strobe_nxt = 1'b1;
          out_value_nxt  = add_y;
          out_err_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      len_r        <= LEN_RESET;
      pend_r       <= 1'b0;
      b_pend_r     <= 1'b0;
      i_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_r       <= pend_nxt;
      b_pend_r     <= b_pend_nxt;
      i_r          <= i_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_i_r       <= b_i_nxt;
    pend_addr_r <= pend_addr_nxt;
    amt_r       <= amt_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  rapq_ram #(
    .DEPTH (MAX_ELEMENTS)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (tree_wr_en),
    .wr_addr (tree_wr_addr),
    .wr_data (tree_wr_data),
    .rd_en   (tree_rd_en),
    .rd_addr (rd_addr),
    .rd_data (tree_rd_data)
  );

  rapq_ram #(
    .DEPTH (MAX_ELEMENTS)
  ) u_base_ram (
    .clk     (clk),
    .wr_en   (base_wr_en),
    .wr_addr (base_addr),
    .wr_data (in_amount),
    .rd_en   (base_rd_en),
    .rd_addr (base_addr),
    .rd_data (base_rd_data)
  );

  assign out_strobe        = out_strobe_r;
  assign out_element_value = out_value_r;
  assign out_index_error   = out_err_r;

endmodule

`default_nettype wire
